@@ hw/rtl/ile_pkg.sv @@
package ile_pkg;

  typedef logic [2:0]  cmd_t;
  typedef logic [1:0]  status_t;
  typedef logic [31:0] word_t;

  localparam cmd_t CMD_ADD_HEAD  = 3'd0;
  localparam cmd_t CMD_ADD_TAIL  = 3'd1;
  localparam cmd_t CMD_ADD_AT    = 3'd2;
  localparam cmd_t CMD_GET       = 3'd3;
  localparam cmd_t CMD_DEL_AT    = 3'd4;
  localparam cmd_t CMD_DEL_VALUE = 3'd5;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_RANGE    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  localparam word_t READ_MISS = 32'hFFFF_FFFF;

endpackage

@@ hw/rtl/indexed_list_engine.sv @@
// Range errors, full and unused commands go straight to the result; a get waits for its memory read;
// inserts and deletes move or search entries first, a delete by value over a full list being the
// longest case.
// One request at a time: the next one is taken the cycle after the result is loaded,
// and result stalls hold it back. The single read port moves or compares one entry per cycle.
// Reset (rst, synchronous, active high) empties the list and clears the output valid.
module indexed_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  ile_pkg::cmd_t       command,
  input  logic [6:0]          position,
  input  logic signed [31:0]  item_value,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output ile_pkg::status_t    status,
  output logic signed [31:0]  read_value,
  output logic [6:0]          entry_count
);
  import ile_pkg::*;

  // AW addresses the memory; CW holds a count from 0 to CAPACITY.
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  // compare width wide enough for both the 7-bit position and the count
  localparam int CMPW = (CW > 7) ? CW : 7;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SHIFT_UP = 3'd1;  // open a gap, tail toward position
  localparam logic [2:0] S_SHIFT_DN = 3'd2;  // search and/or close a gap
  localparam logic [2:0] S_GET_WAIT = 3'd3;  // memory read in flight
  localparam logic [2:0] S_FINISH   = 3'd4;  // hand result to output register

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;       // scan pointer (next source index, or one above it)
  logic [CW-1:0] ins_pos;   // target slot of an insert
  logic [AW-1:0] src_q;     // address whose data is in rdata
  logic          rd_pend;   // rdata holds mem[src_q]
  logic          found;     // delete: gap position known, shifting active
  word_t         val_q;
  status_t       status_q;
  word_t         rdval_q;

  // memory port controls
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;

  logic            accept;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] tgt;        // insert target for add commands
  logic            is_add;
  logic            list_full;
  logic            pos_ok;     // position < count
  logic            up_issue;
  logic            dn_issue;
  logic            val_hit;
  logic            out_free;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign pos_ext   = CMPW'(position);
  assign cnt_ext   = CMPW'(count);
  assign list_full = (count == CW'(CAPACITY));
  assign pos_ok    = (pos_ext < cnt_ext);
  assign is_add    = (command == CMD_ADD_HEAD) || (command == CMD_ADD_TAIL) ||
                     (command == CMD_ADD_AT);
  assign up_issue  = (ptr > ins_pos);
  assign dn_issue  = (ptr < count);
  assign val_hit   = (mem_rdata == val_q);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    case (command)
      CMD_ADD_HEAD: tgt = '0;
      CMD_ADD_TAIL: tgt = cnt_ext;
      default:      tgt = pos_ext;
    endcase
  end

  // One read and one write per cycle. Shifts are pipelined: the read issued
  // this cycle lands in rdata next cycle and is written one slot over.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_IDLE: begin
        mem_re    = accept && (command == CMD_GET) && pos_ok;
        mem_raddr = AW'(position);
      end
      S_SHIFT_UP: begin
        mem_re    = up_issue;
        mem_raddr = AW'(ptr - 1'b1);
        if (rd_pend) begin
          mem_we    = 1'b1;
          mem_waddr = src_q + 1'b1;
        end else if (!up_issue) begin
          // gap is open: drop the new value in
          mem_we    = 1'b1;
          mem_waddr = AW'(ins_pos);
          mem_wdata = val_q;
        end
      end
      S_SHIFT_DN: begin
        mem_re    = dn_issue;
        mem_raddr = AW'(ptr);
        mem_we    = rd_pend && found;
        mem_waddr = src_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  ile_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a result taken while the next one is ready is replaced in S_FINISH
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            val_q   <= item_value;
            rd_pend <= 1'b0;
            // a get past the end reads back -1; a good get loads rdval_q later
            rdval_q <= ((command == CMD_GET) && !pos_ok) ? READ_MISS : '0;
            if (is_add) begin
              // position is checked before fullness
              if (tgt > cnt_ext) begin
                status_q <= ST_RANGE;
                state    <= S_FINISH;
              end else if (list_full) begin
                status_q <= ST_FULL;
                state    <= S_FINISH;
              end else begin
                status_q <= ST_OK;
                ins_pos  <= CW'(tgt);
                ptr      <= count;
                state    <= S_SHIFT_UP;
              end
            end else begin
              case (command)
                CMD_GET: begin
                  if (pos_ok) begin
                    status_q <= ST_OK;
                    state    <= S_GET_WAIT;
                  end else begin
                    status_q <= ST_RANGE;
                    state    <= S_FINISH;
                  end
                end
                CMD_DEL_AT: begin
                  if (pos_ok) begin
                    status_q <= ST_OK;
                    ptr      <= CW'(position) + 1'b1;
                    found    <= 1'b1;
                    state    <= S_SHIFT_DN;
                  end else begin
                    status_q <= ST_RANGE;
                    state    <= S_FINISH;
                  end
                end
                CMD_DEL_VALUE: begin
                  status_q <= ST_OK;
                  ptr      <= '0;
                  found    <= 1'b0;
                  state    <= S_SHIFT_DN;
                end
                default: begin
                  status_q <= ST_OK;
                  state    <= S_FINISH;
                end
              endcase
            end
          end
        end
        S_SHIFT_UP: begin
          rd_pend <= up_issue;
          if (up_issue) begin
            ptr   <= ptr - 1'b1;
            src_q <= AW'(ptr - 1'b1);
          end else if (!rd_pend) begin
            count <= count + 1'b1;
            state <= S_FINISH;
          end
        end
        S_SHIFT_DN: begin
          rd_pend <= dn_issue;
          if (dn_issue) begin
            ptr   <= ptr + 1'b1;
            src_q <= AW'(ptr);
          end
          if (rd_pend && !found && val_hit) begin
            found <= 1'b1;
          end
          if (!dn_issue && !rd_pend) begin
            if (found) begin
              count <= count - 1'b1;
            end else begin
              status_q <= ST_NOTFOUND;
            end
            state <= S_FINISH;
          end
        end
        S_GET_WAIT: begin
          rdval_q <= mem_rdata;
          state   <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= status_q;
            read_value  <= rdval_q;
            entry_count <= 7'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/ile_ram.sv @@
module ile_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  ile_pkg::word_t    wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output ile_pkg::word_t    rdata
);
  import ile_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sim/ile_checker.sv @@
module ile_checker #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ile_pkg::cmd_t      command,
  input  logic [6:0]         position,
  input  logic signed [31:0] item_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ile_pkg::status_t   status,
  input  logic signed [31:0] read_value,
  input  logic [6:0]         entry_count,
  output int                 fails,
  output int                 pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;

  typedef struct packed {
    status_t    status;
    word_t      read_value;
    logic [6:0] entry_count;
  } outcome_t;

  // shadow copy of the list, head at index 0
  word_t    shadow_list [CAPACITY];
  int       shadow_len;
  outcome_t pending_outcomes [$];

  function automatic status_t shadow_insert(int at, word_t val);
    int i;
    if (at > shadow_len) return ST_RANGE;   // position checked before fullness
    if (shadow_len >= CAPACITY) return ST_FULL;
    for (i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[at] = val;
    shadow_len++;
    return ST_OK;
  endfunction

  function automatic void shadow_remove(int at);
    int i;
    for (i = at; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_len--;
  endfunction

  function automatic outcome_t list_outcome(cmd_t cmd, logic [6:0] pos, word_t val);
    outcome_t o;
    int       i;
    int       hit;
    o.status     = ST_OK;
    o.read_value = '0;
    hit          = -1;
    case (cmd)
      CMD_ADD_HEAD: o.status = shadow_insert(0, val);
      CMD_ADD_TAIL: o.status = shadow_insert(shadow_len, val);
      CMD_ADD_AT:   o.status = shadow_insert(int'(pos), val);
      CMD_GET: begin
        if (int'(pos) < shadow_len) begin
          o.read_value = shadow_list[pos];
        end else begin
          o.status     = ST_RANGE;
          o.read_value = READ_MISS;
        end
      end
      CMD_DEL_AT: begin
        if (int'(pos) < shadow_len) shadow_remove(int'(pos));
        else o.status = ST_RANGE;
      end
      CMD_DEL_VALUE: begin
        for (i = 0; i < shadow_len && hit < 0; i++) begin
          if (shadow_list[i] == val) hit = i;
        end
        if (hit >= 0) shadow_remove(hit);
        else o.status = ST_NOTFOUND;
      end
      default: ;   // spare codes leave the list alone
    endcase
    o.entry_count = shadow_len[6:0];
    return o;
  endfunction

  task automatic report(string what);
    $display("%0t mismatch: %s", $time, what);
    fails++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      pending_outcomes.delete();
      shadow_len = 0;
      pending <= 0;
    end else begin
      // results first: a request taken on this edge cannot already have answered
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          report($sformatf("result with no request outstanding (status %0d count %0d)",
                           status, entry_count));
        end else begin
          want = pending_outcomes.pop_front();
          if (status !== want.status)
            report($sformatf("status %0d, want %0d", status, want.status));
          if (read_value !== want.read_value)
            report($sformatf("read_value %0d, want %0d", read_value,
                             $signed(want.read_value)));
          if (entry_count !== want.entry_count)
            report($sformatf("entry_count %0d, want %0d", entry_count,
                             want.entry_count));
        end
      end
      if (in_valid && !in_stall)
        pending_outcomes.push_back(list_outcome(command, position, item_value));
      pending <= pending_outcomes.size();
    end
  end

endmodule

@@ sim/tb_indexed_list_engine.sv @@
module tb_indexed_list_engine;

  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;

  localparam int CAPACITY = 64;
  // codes the block does not define; it must answer them and leave the list alone
  localparam cmd_t CMD_SPARE_LO = 3'd6;
  localparam cmd_t CMD_SPARE_HI = 3'd7;
  // worst request is a full shift or search plus pipeline overhead
  localparam int SETTLE_CYCLES = 4 * (CAPACITY + 3);
  // cycles with no handshake on either channel before we call it hung
  localparam int HANG_LIMIT    = 4000;
  localparam int PHASES        = 8;
  localparam int PHASE_LEN     = 150;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  cmd_t               command = CMD_ADD_HEAD;
  logic [6:0]         position = '0;
  logic signed [31:0] item_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  status_t            status;
  logic signed [31:0] read_value;
  logic [6:0]         entry_count;

  int fails;
  int pending;

  bit calm  = 1'b0;   // no idling on either side
  bit gappy = 1'b1;   // sender may insert gaps in this phase

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  indexed_list_engine #(.CAPACITY(CAPACITY)) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .position   (position),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .read_value (read_value),
    .entry_count(entry_count)
  );

  ile_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .position   (position),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .read_value (read_value),
    .entry_count(entry_count),
    .fails      (fails),
    .pending    (pending)
  );

  // Present one request and hold it until the block takes it. An optional
  // idle burst goes in front; valid only drops when a burst actually happens,
  // so back-to-back requests keep valid high across the edge.
  task automatic issue(cmd_t c, logic [6:0] p, word_t v);
    int gap;
    gap = 0;
    if (!calm && gappy && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= c;
    position   <= p;
    item_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Fill phases lean on inserts so the list reaches full and the full/range
  // checks at capacity get exercised; drain phases lean on deletes and reads.
  function automatic cmd_t pick_command(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 25) return CMD_ADD_HEAD;
      if (r < 50) return CMD_ADD_TAIL;
      if (r < 70) return CMD_ADD_AT;
      if (r < 80) return CMD_GET;
      if (r < 88) return CMD_DEL_AT;
      if (r < 96) return CMD_DEL_VALUE;
    end else begin
      if (r < 5)  return CMD_ADD_HEAD;
      if (r < 10) return CMD_ADD_TAIL;
      if (r < 15) return CMD_ADD_AT;
      if (r < 30) return CMD_GET;
      if (r < 65) return CMD_DEL_AT;
      if (r < 96) return CMD_DEL_VALUE;
    end
    return ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  // Often near the head, more often anywhere in range, sometimes past capacity.
  function automatic logic [6:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 7'($urandom_range(0, 8));
    if (r < 9) return 7'($urandom_range(0, CAPACITY));
    return 7'($urandom_range(CAPACITY + 1, 127));
  endfunction

  // A small pool of values makes duplicates common, so delete-by-value
  // finds matches; the rest are full 32-bit randoms.
  function automatic word_t pick_value();
    if ($urandom_range(0, 9) < 6) return word_t'($urandom_range(0, 15)) - 32'd8;
    return $urandom();
  endfunction

  // Result side backpressure: random stall bursts, none in reset or in the calm phase.
  initial begin : result_backpressure
    int n;
    forever begin
      @(posedge clk);
      if (!rst && !calm && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Hang detector: ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int k;
    bit filling;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed: empty list corner cases ---
    issue(CMD_GET,       7'd0,   32'd0);           // read on empty: range, -1
    issue(CMD_DEL_AT,    7'd0,   32'd0);           // delete on empty
    issue(CMD_DEL_VALUE, 7'd0,   32'd5);           // no match on empty
    issue(CMD_ADD_AT,    7'd1,   32'd1);           // index past count
    // build [min, -1, max, 0] then push a marker onto the head
    issue(CMD_ADD_HEAD,  7'd0,   32'h8000_0000);
    issue(CMD_ADD_TAIL,  7'd0,   32'h7FFF_FFFF);
    issue(CMD_ADD_AT,    7'd1,   32'hFFFF_FFFF);
    issue(CMD_ADD_AT,    7'd3,   32'd0);           // index equal to count = append
    issue(CMD_ADD_AT,    7'd0,   32'h5555_5555);
    issue(CMD_GET,       7'd0,   32'd0);
    issue(CMD_GET,       7'd4,   32'd0);           // last entry
    issue(CMD_GET,       7'd5,   32'd0);           // one past the end
    issue(CMD_GET,       7'd127, 32'd0);
    issue(CMD_ADD_AT,    7'd127, 32'd9);
    issue(CMD_DEL_VALUE, 7'd0,   32'h5555_5555);   // match at head
    issue(CMD_DEL_VALUE, 7'd0,   32'd0);           // match at tail
    issue(CMD_DEL_VALUE, 7'd0,   32'hAAAA_AAAA);   // no match
    issue(CMD_DEL_AT,    7'd0,   32'd0);           // head
    issue(CMD_DEL_AT,    7'd1,   32'd0);           // tail
    issue(CMD_DEL_AT,    7'd64,  32'd0);
    issue(CMD_SPARE_LO,  7'd127, 32'hAAAA_AAAA);
    issue(CMD_SPARE_HI,  7'd0,   32'h5555_5555);
    issue(CMD_ADD_TAIL,  7'd0,   32'hFFFF_FFFF);   // duplicate value
    issue(CMD_DEL_VALUE, 7'd0,   32'hFFFF_FFFF);   // must take the first one
    issue(CMD_DEL_AT,    7'd0,   32'd0);           // back to empty

    // --- random: alternate fill and drain phases, last one without idling ---
    for (phase = 0; phase < PHASES; phase++) begin
      filling = (phase % 2) == 0;
      gappy   = $urandom_range(0, 3) != 0;
      calm    = (phase == PHASES - 1);
      for (k = 0; k < PHASE_LEN; k++)
        issue(pick_command(filling), pick_position(), pick_value());
    end
    in_valid <= 1'b0;

    // drain: let the checker catch up, then allow for stragglers
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ile_pkg.sv
hw/rtl/ile_ram.sv
hw/rtl/indexed_list_engine.sv
sim/ile_checker.sv
sim/tb_indexed_list_engine.sv
